>>> src/global_safepoint_arbiter_defines.svh
// ----------------------------------------------------------------------------
// global_safepoint_arbiter_defines
// assertion macros for the safepoint arbiter
// ----------------------------------------------------------------------------
`ifndef GLOBAL_SAFEPOINT_ARBITER_DEFINES_SVH
`define GLOBAL_SAFEPOINT_ARBITER_DEFINES_SVH

`ifndef SYNTH
`define GSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gsa check failed");
`define GSA_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("gsa check failed");
`else
`define GSA_ASSERT(lbl, prop)
`define GSA_NEVER(lbl, cond)
`endif

`endif

>>> src/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg
// shared constants, types and helpers of the safepoint arbiter
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int NUM_CORES   = 16;
  localparam int QUEUE_DEPTH = 16;

  localparam int CIW     = $clog2(NUM_CORES);
  localparam int QIW     = $clog2(QUEUE_DEPTH);
  localparam int QCW     = $clog2(QUEUE_DEPTH + 1);
  localparam int QSW     = $clog2(2 * QUEUE_DEPTH);
  localparam int MAX_MSG = NUM_CORES + 3;
  localparam int NW      = $clog2(MAX_MSG + 1);

  localparam logic [1:0] MODE_REQ  = 2'd0;
  localparam logic [1:0] MODE_REL  = 2'd1;
  localparam logic [1:0] MODE_SAFE = 2'd2;
  localparam logic [1:0] MODE_RSV  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_VIOL = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [0:0] CFG_OWN_CORE = 1'd0;
  localparam logic [0:0] CFG_PRESENT  = 1'd1;

  typedef logic [NUM_CORES-1:0] cset_t;

  typedef enum logic [1:0] {
    MK_NONE  = 2'd0,
    MK_SPIN  = 2'd1,
    MK_STOP  = 2'd2,
    MK_GRANT = 2'd3
  } mk_t;

  typedef enum logic [1:0] {
    EV_REQ  = 2'd0,
    EV_REL  = 2'd1,
    EV_SAFE = 2'd2,
    EV_BAD  = 2'd3
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t        kind;
    logic [CIW-1:0]  core;
    logic [31:0]     seq;
    logic            was;
  } ev_t;

  typedef struct packed {
    mk_t             kind;
    logic [CIW-1:0]  dest;
    logic [CIW-1:0]  forw;
    logic [31:0]     seq;
    logic [1:0]      status;
  } msg_t;

  typedef struct packed {
    logic [QCW-1:0]  q_cnt;
  } eng_stat_t;

  function automatic cset_t onehot(input logic [CIW-1:0] c);
    return cset_t'(1) << c;
  endfunction

  function automatic logic [CIW-1:0] lowest(input cset_t s);
    logic [CIW-1:0] r;
    r = '0;
    for (int i = NUM_CORES - 1; i >= 0; i--) begin
      if (s[i]) r = CIW'(i);
    end
    return r;
  endfunction

endpackage

>>> src/gsa_ifs.sv
// ----------------------------------------------------------------------------
// gsa_ifs
// event and message channels of the safepoint arbiter
// ----------------------------------------------------------------------------
interface gsa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  core;
  logic [31:0] seq_no;
  logic        prior_spin;

  modport source(output valid, mode, core, seq_no, prior_spin, input ready);
  modport sink(input valid, mode, core, seq_no, prior_spin, output ready);
endinterface

interface gsa_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  msg_kind;
  logic [3:0]  dest_core;
  logic [3:0]  grantee;
  logic [31:0] msg_seq;
  logic [1:0]  status;
  logic        last;

  modport source(output valid, msg_kind, dest_core, grantee, msg_seq, status, last,
                 input ready);
  modport sink(input valid, msg_kind, dest_core, grantee, msg_seq, status, last,
               output ready);
endinterface

>>> src/gsa_front.sv
// ----------------------------------------------------------------------------
// gsa_front
// takes event beats, sorts out malformed ones and queues them for the engine
// ----------------------------------------------------------------------------
module gsa_front
  import gsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  gsa_in_if.sink      in_ch,
  output ev_t         ev_o,
  output logic        ev_vld_o,
  input  logic        ev_pop_i
);

  ev_t        q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  ev_t        ev_in;
  logic       push;

  always_comb begin
    ev_in.core = CIW'(in_ch.core);
    ev_in.seq  = in_ch.seq_no;
    ev_in.was  = in_ch.prior_spin;
    if (in_ch.mode == MODE_RSV || int'(in_ch.core) >= NUM_CORES) begin
      ev_in.kind = EV_BAD;
    end else begin
      unique case (in_ch.mode)
        MODE_REQ:  ev_in.kind = EV_REQ;
        MODE_REL:  ev_in.kind = EV_REL;
        MODE_SAFE: ev_in.kind = EV_SAFE;
        default:   ev_in.kind = EV_BAD;
      endcase
    end
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign ev_vld_o    = (cnt_r != 2'd0);
  assign ev_o        = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= ev_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (ev_pop_i) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(ev_pop_i);
    end
  end

endmodule

>>> src/gsa_engine.sv
// ----------------------------------------------------------------------------
// gsa_engine
// applies one event to the arbiter state and steps out its messages
// ----------------------------------------------------------------------------
module gsa_engine
  import gsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  input  ev_t         ev_i,
  input  logic        ev_vld_i,
  output logic        ev_pop_o,
  gsa_out_if.source   out_ch,
  output eng_stat_t   stat_o
);

  typedef enum logic [1:0] {S_IDLE, S_STEP, S_LAST} state_t;

  state_t          state_r;
  logic [3:0]      own_core_r;
  logic [15:0]     present_r;
  logic [CIW-1:0]  acore_r [QUEUE_DEPTH];
  logic [31:0]     aseq_r  [QUEUE_DEPTH];
  logic [QIW-1:0]  head_r;
  logic [QCW-1:0]  cnt_r;
  logic            holder_vld_r;
  logic [CIW-1:0]  holder_r;
  logic [31:0]     cur_seq_r;
  logic [31:0]     req_ctr_r;
  cset_t           spin_r, asked_r;
  logic [31:0]     asked_seq_r [NUM_CORES];
  msg_t            pend_r;
  logic            pend_vld_r;
  logic [NW-1:0]   n_r;
  msg_t            out_msg_r;
  logic            out_last_r, out_vld_r;

  logic [CIW-1:0]  me, g;
  logic [31:0]     s;
  cset_t           present_m, sa, needed, cand;
  logic            st_vld, take, out_free, out_load, rel_stop;
  msg_t            st_msg;
  logic            ev_bad, ev_full, fifo_wr;
  logic [QSW-1:0]  tail_sum, head_sum;
  logic [QIW-1:0]  tail, head_nxt;

  assign me        = (int'(own_core_r) >= NUM_CORES) ? '0 : CIW'(own_core_r);
  assign present_m = cset_t'(present_r);
  assign g         = acore_r[head_r];
  assign s         = aseq_r[head_r];
  assign sa        = spin_r | asked_r;
  assign needed    = present_m & ~onehot(g);
  assign cand      = needed & ~sa & ~onehot(me);
  assign out_free  = !out_vld_r || out_ch.ready;

  assign tail_sum = QSW'(head_r) + QSW'(cnt_r);
  assign tail     = (tail_sum >= QSW'(QUEUE_DEPTH)) ? QIW'(tail_sum - QSW'(QUEUE_DEPTH))
                                                    : QIW'(tail_sum);
  assign head_sum = QSW'(head_r) + QSW'(1);
  assign head_nxt = (head_sum >= QSW'(QUEUE_DEPTH)) ? '0 : QIW'(head_sum);

  // one step of the arbitration rule
  always_comb begin
    st_vld        = 1'b0;
    st_msg.kind   = MK_NONE;
    st_msg.dest   = '0;
    st_msg.forw   = '0;
    st_msg.seq    = '0;
    st_msg.status = ST_OK;
    priority if (holder_vld_r) begin
      st_vld = 1'b0;
    end else if (cnt_r == '0) begin
      st_vld      = |spin_r;
      st_msg.kind = MK_STOP;
      st_msg.dest = lowest(spin_r);
      st_msg.seq  = cur_seq_r;
    end else if (sa[g]) begin
      st_vld      = 1'b1;
      st_msg.kind = MK_STOP;
      st_msg.dest = g;
      st_msg.seq  = s;
    end else if (|cand) begin
      st_vld      = 1'b1;
      st_msg.kind = MK_SPIN;
      st_msg.dest = lowest(cand);
      st_msg.forw = g;
      st_msg.seq  = s;
    end else if (!sa[me] && g != me) begin
      st_vld      = 1'b1;
      st_msg.kind = MK_SPIN;
      st_msg.dest = me;
      st_msg.forw = g;
      st_msg.seq  = s;
    end else if (needed == spin_r) begin
      st_vld      = 1'b1;
      st_msg.kind = MK_GRANT;
      st_msg.dest = g;
      st_msg.seq  = s;
    end else begin
      st_vld = 1'b0;
    end
  end

  assign take = st_vld && (n_r < NW'(MAX_MSG));

  always_comb begin
    ev_bad  = 1'b0;
    ev_full = 1'b0;
    unique case (ev_i.kind)
      EV_REQ:  ev_full = (cnt_r >= QCW'(QUEUE_DEPTH));
      EV_REL:  ev_bad  = !(holder_vld_r && holder_r == ev_i.core);
      EV_SAFE: ev_bad  = holder_vld_r || cnt_r == '0 || asked_seq_r[ev_i.core] == '1 ||
                         asked_seq_r[ev_i.core] != ev_i.seq ||
                         (!ev_i.was && spin_r[ev_i.core]);
      EV_BAD:  ev_bad  = 1'b1;
      default: ev_bad  = 1'b1;
    endcase
  end

  assign rel_stop = (ev_i.kind == EV_REL) && !ev_bad && spin_r[me];

  assign ev_pop_o = (state_r == S_IDLE) && ev_vld_i;
  assign fifo_wr  = ev_pop_o && ev_i.kind == EV_REQ && !ev_full;

  assign out_load = out_free && ((state_r == S_LAST) ||
                                 (state_r == S_STEP && take && pend_vld_r));

  always_ff @(posedge clk) begin
    if (fifo_wr) begin
      acore_r[tail] <= ev_i.core;
      aseq_r[tail]  <= req_ctr_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      own_core_r   <= '0;
      present_r    <= '1;
      head_r       <= '0;
      cnt_r        <= '0;
      holder_vld_r <= 1'b0;
      holder_r     <= '0;
      cur_seq_r    <= '0;
      req_ctr_r    <= '0;
      spin_r       <= '0;
      asked_r      <= '0;
      for (int i = 0; i < NUM_CORES; i++) asked_seq_r[i] <= '1;
      pend_vld_r   <= 1'b0;
      n_r          <= '0;
      out_vld_r    <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_OWN_CORE: own_core_r <= cfg_wdata[3:0];
          CFG_PRESENT:  present_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_load) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (ev_vld_i) begin
            pend_vld_r    <= rel_stop;
            n_r           <= rel_stop ? NW'(1) : '0;
            pend_r.kind   <= rel_stop ? MK_STOP : MK_NONE;
            pend_r.dest   <= rel_stop ? me : '0;
            pend_r.forw   <= '0;
            pend_r.seq    <= rel_stop ? cur_seq_r : '0;
            pend_r.status <= ev_bad ? ST_VIOL : (ev_full ? ST_FULL : ST_OK);
            if (ev_bad || ev_full) begin
              state_r <= S_LAST;
            end else begin
              state_r <= S_STEP;
              unique case (ev_i.kind)
                EV_REQ: begin
                  req_ctr_r <= req_ctr_r + 32'd1;
                  cnt_r     <= cnt_r + QCW'(1);
                end
                EV_REL: begin
                  holder_vld_r <= 1'b0;
                  if (rel_stop) begin
                    spin_r  <= spin_r & ~onehot(me);
                    asked_r <= asked_r & ~onehot(me);
                  end
                end
                EV_SAFE: begin
                  asked_r  <= asked_r & ~onehot(ev_i.core);
                  spin_r   <= spin_r | onehot(ev_i.core);
                  asked_seq_r[ev_i.core] <= '1;
                end
                default: ;
              endcase
            end
          end
        end
        S_STEP: begin
          if (take) begin
            if (!pend_vld_r || out_free) begin
              if (pend_vld_r) begin
                out_msg_r  <= pend_r;
                out_last_r <= 1'b0;
              end
              pend_r     <= st_msg;
              pend_vld_r <= 1'b1;
              n_r        <= n_r + NW'(1);
              unique case (st_msg.kind)
                MK_STOP: begin
                  spin_r  <= spin_r & ~onehot(st_msg.dest);
                  asked_r <= asked_r & ~onehot(st_msg.dest);
                end
                MK_SPIN: begin
                  asked_r <= asked_r | onehot(st_msg.dest);
                  asked_seq_r[st_msg.dest] <= st_msg.seq;
                end
                MK_GRANT: begin
                  holder_vld_r <= 1'b1;
                  holder_r     <= g;
                  cur_seq_r    <= s;
                  head_r       <= head_nxt;
                  cnt_r        <= cnt_r - QCW'(1);
                end
                default: ;
              endcase
            end
          end else begin
            if (!pend_vld_r) begin
              pend_r.kind   <= MK_NONE;
              pend_r.dest   <= '0;
              pend_r.forw   <= '0;
              pend_r.seq    <= '0;
              pend_r.status <= ST_OK;
              pend_vld_r    <= 1'b1;
            end
            state_r <= S_LAST;
          end
        end
        S_LAST: begin
          if (out_free) begin
            out_msg_r  <= pend_r;
            out_last_r <= 1'b1;
            pend_vld_r <= 1'b0;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.msg_kind  = out_msg_r.kind;
  assign out_ch.dest_core = 4'(out_msg_r.dest);
  assign out_ch.grantee   = 4'(out_msg_r.forw);
  assign out_ch.msg_seq   = out_msg_r.seq;
  assign out_ch.status    = out_msg_r.status;
  assign out_ch.last      = out_last_r;

  assign stat_o.q_cnt = cnt_r;

endmodule

>>> src/global_safepoint_arbiter.sv
// ----------------------------------------------------------------------------
// global_safepoint_arbiter
// Grants one core at a time an exclusive world-stop. Event beats (request,
// release, safe report) enter a two-entry queue; the engine applies one event
// and then runs the step rule, one message per cycle while the result side
// keeps up, up to NUM_CORES + 3 messages. An ignored event goes from the apply
// state straight to the last beat; an accepted one runs the step state first,
// giving a single none beat if the rule sends nothing. Results leave through
// an output register; result stalls hold the engine. Every event ends with a
// beat marked last; ignored events yield one none beat carrying the status.
// ----------------------------------------------------------------------------
`include "global_safepoint_arbiter_defines.svh"

module global_safepoint_arbiter
  import gsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  gsa_in_if.sink      in_ch,
  gsa_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  ev_t       ev;
  logic      ev_vld, ev_pop;
  eng_stat_t eng_stat;

  gsa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .ev_o     (ev),
    .ev_vld_o (ev_vld),
    .ev_pop_i (ev_pop)
  );

  gsa_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .ev_i      (ev),
    .ev_vld_i  (ev_vld),
    .ev_pop_o  (ev_pop),
    .out_ch    (out_ch),
    .stat_o    (eng_stat)
  );

  `GSA_ASSERT(a_hold, out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.msg_seq))
  `GSA_ASSERT(a_none_is_last, (out_ch.valid && out_ch.msg_kind == MK_NONE) |-> out_ch.last)
  `GSA_NEVER(a_queue_bound, eng_stat.q_cnt > QCW'(QUEUE_DEPTH))

endmodule
